@@ hdl/hcs_pkg.sv @@
// ----------------------------------------------------------------------------
// hcs_pkg
// Types and constants shared by the contrast stretch block.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int NUM_LEVELS = 256;
    localparam int LEVEL_W    = 8;
    localparam int COUNT_W    = 17;
    localparam int FRAC_W     = 17;
    localparam int FRAC_BITS  = 16;
    localparam int CUT_W      = 2 * COUNT_W - FRAC_BITS;   // 18
    localparam int CUM_W      = COUNT_W + LEVEL_W;         // 25
    localparam int CMD_W      = 2;
    localparam int REG_IDX_W  = 1;
    localparam logic [LEVEL_W-1:0] TOP_LEVEL = 8'd255;

    localparam logic [CMD_W-1:0] CMD_ACCUM  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MAP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;   // unused, ignored

    localparam logic [REG_IDX_W-1:0] REG_LOW_FRACTION  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_FRACTION = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SCAN_RD,
        ST_SCAN_ACC,
        ST_DIV_INIT,
        ST_DIV,
        ST_FILL,
        ST_EMIT
    } hcs_state_t;

    typedef struct packed {
        logic accept;
        logic inc;
        logic mul_lo;
        logic mul_hi;
        logic scan_rd;
        logic scan_acc;
        logic div_start;
        logic div_step;
        logic fill;
        logic finish_clear;
        logic load_out;
    } hcs_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic div_last;
        logic fill_last;
        logic out_free;
    } hcs_status_t;

endpackage

@@ hdl/hcs_req_if.sv @@
// ----------------------------------------------------------------------------
// hcs_req_if
// Request channel: command and pixel with valid/ready.
// ----------------------------------------------------------------------------
interface hcs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] pixel_in;

    modport source (output valid, command, pixel_in, input ready);
    modport sink   (input valid, command, pixel_in, output ready);
endinterface

@@ hdl/hcs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// hcs_rsp_if
// Response channel: mapped pixel or report with valid/ready.
// ----------------------------------------------------------------------------
interface hcs_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic [7:0] low_index;
    logic [7:0] high_index;
    logic       is_report;

    modport source (output valid, pixel_out, low_index, high_index, is_report, input ready);
    modport sink   (input valid, pixel_out, low_index, high_index, is_report, output ready);
endinterface

@@ hdl/hcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// hcs_ctrl
// Sequencer for accumulate, finish (scan, divide, map fill) and map lookup.
// ----------------------------------------------------------------------------
module hcs_ctrl
    import hcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic [CMD_W-1:0]    req_command,
    output logic                req_ready,
    input  hcs_status_t         status,
    output hcs_cmd_t            cmd
);

    hcs_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (req_command)
                        CMD_ACCUM:  state_next = ST_INC;
                        CMD_FINISH: state_next = ST_MUL_LO;
                        CMD_MAP:    state_next = ST_EMIT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INC:
            begin
                cmd.inc    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_ACC;
            end
            ST_SCAN_ACC:
            begin
                cmd.scan_acc = 1'b1;
                state_next   = status.scan_done ? ST_DIV_INIT : ST_SCAN_RD;
            end
            ST_DIV_INIT:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_FILL;
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (status.fill_last)
                begin
                    cmd.finish_clear = 1'b1;
                    state_next       = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ hdl/hcs_datapath.sv @@
// ----------------------------------------------------------------------------
// hcs_datapath
// Histogram and map memories, cut multiplier, bound scan, divider, output reg.
// ----------------------------------------------------------------------------
module hcs_datapath
    import hcs_pkg::*;
#(
    parameter logic [COUNT_W-1:0] COUNT_CAP = 17'd65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [FRAC_W-1:0]    cfg_data,
    input  logic [CMD_W-1:0]     req_command,
    input  logic [LEVEL_W-1:0]   req_pixel,
    input  hcs_cmd_t             cmd,
    output hcs_status_t          status,
    input  logic                 rsp_ready,
    output logic                 rsp_valid,
    output logic [LEVEL_W-1:0]   rsp_pixel,
    output logic [LEVEL_W-1:0]   rsp_low,
    output logic [LEVEL_W-1:0]   rsp_high,
    output logic                 rsp_report
);

    logic [FRAC_W-1:0]  low_frac_reg, high_frac_reg;
    logic [COUNT_W-1:0] bin_mem [NUM_LEVELS];
    logic [LEVEL_W-1:0] map_mem [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] bin_vld_reg;
    logic [COUNT_W-1:0] bin_rd_reg;
    logic               bin_rdv_reg;
    logic [LEVEL_W-1:0] map_rd_reg;
    logic               map_built_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [LEVEL_W-1:0] pix_reg;
    logic               report_reg;
    logic [CUT_W-1:0]   low_cut_reg, high_cut_reg;
    logic [CUM_W-1:0]   cum_reg;
    logic [LEVEL_W-1:0] idx_reg, lower_reg, upper_reg;
    logic [LEVEL_W-1:0] div_d_reg, div_rem_reg, div_q_reg;
    logic [2:0]         div_cnt_reg;
    logic [LEVEL_W-1:0] acc_q_reg, acc_r_reg;
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] out_pixel_reg, out_low_reg, out_high_reg;
    logic               out_report_reg;

    logic [LEVEL_W-1:0]   rd_addr;
    logic                 bin_rd_en;
    logic [COUNT_W-1:0]   bin_val, bin_inc;
    logic [FRAC_W-1:0]    mul_frac;
    logic [2*COUNT_W-1:0] prod;
    logic [CUM_W-1:0]     cum_next;
    logic                 scan_hit;
    logic [LEVEL_W:0]     div_trial;
    logic [LEVEL_W-1:0]   div_d;
    logic [LEVEL_W:0]     r_sum;
    logic                 carry;
    logic [LEVEL_W+1:0]   q_sum;
    logic [LEVEL_W-1:0]   fill_val, r_new;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_frac_reg  <= '0;
            high_frac_reg <= 17'h10000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOW_FRACTION:  low_frac_reg  <= cfg_data;
                REG_HIGH_FRACTION: high_frac_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign rd_addr   = cmd.accept ? req_pixel : idx_reg;
    assign bin_rd_en = cmd.accept || cmd.scan_rd;
    assign bin_val   = bin_rdv_reg ? bin_rd_reg : '0;
    assign bin_inc   = (bin_val < COUNT_CAP) ? bin_val + 1'b1 : bin_val;

    // histogram memory
    always_ff @(posedge clk)
    begin
        if (cmd.inc)
            bin_mem[pix_reg] <= bin_inc;
        if (bin_rd_en)
            bin_rd_reg <= bin_mem[rd_addr];
    end

    // level map memory; every entry is written by a finish
    always_ff @(posedge clk)
    begin
        if (cmd.fill)
            map_mem[idx_reg] <= fill_val;
        if (cmd.accept)
            map_rd_reg <= map_mem[req_pixel];
    end

    assign mul_frac = cmd.mul_hi ? high_frac_reg : low_frac_reg;
    assign prod     = (2*COUNT_W)'(mul_frac) * (2*COUNT_W)'(total_reg);
    assign cum_next = cum_reg + CUM_W'(bin_val);
    assign scan_hit = CUM_W'(high_cut_reg) < cum_next;

    assign div_d     = (upper_reg > lower_reg) ? upper_reg - lower_reg : 8'd1;
    // dividend is 255: every shifted-in bit is one
    assign div_trial = {div_rem_reg, 1'b1};

    // incremental (k*255)/d with q0 = 255/d, r0 = 255%d
    assign r_sum    = {1'b0, acc_r_reg} + {1'b0, div_rem_reg};
    assign carry    = r_sum >= {1'b0, div_d_reg};
    assign r_new    = carry ? LEVEL_W'(r_sum - {1'b0, div_d_reg}) : r_sum[LEVEL_W-1:0];
    assign q_sum    = {2'b0, acc_q_reg} + {2'b0, div_q_reg} + {{(LEVEL_W+1){1'b0}}, carry};
    assign fill_val = (idx_reg <= lower_reg) ? '0
                    : (q_sum > {2'b0, TOP_LEVEL}) ? TOP_LEVEL : q_sum[LEVEL_W-1:0];

    assign status.scan_done = scan_hit || (idx_reg == TOP_LEVEL);
    assign status.div_last  = (div_cnt_reg == 3'd0);
    assign status.fill_last = (idx_reg == TOP_LEVEL);
    assign status.out_free  = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg   <= '0;
            bin_rdv_reg   <= 1'b0;
            total_reg     <= '0;
            map_built_reg <= 1'b0;
            lower_reg     <= '0;
            upper_reg     <= TOP_LEVEL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (bin_rd_en)
                bin_rdv_reg <= bin_vld_reg[rd_addr];
            if (cmd.inc)
            begin
                bin_vld_reg[pix_reg] <= 1'b1;
                if (total_reg < COUNT_CAP)
                    total_reg <= total_reg + 1'b1;
            end
            if (cmd.mul_hi)
            begin
                lower_reg <= '0;
                upper_reg <= TOP_LEVEL;
            end
            if (cmd.scan_acc)
            begin
                if (CUM_W'(low_cut_reg) > cum_next)
                    lower_reg <= idx_reg;
                if (scan_hit)
                    upper_reg <= idx_reg;
            end
            if (cmd.finish_clear)
            begin
                bin_vld_reg   <= '0;
                total_reg     <= '0;
                map_built_reg <= 1'b1;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg    <= req_pixel;
            report_reg <= (req_command == CMD_FINISH);
        end
        if (cmd.mul_lo)
            low_cut_reg <= prod[2*COUNT_W-1:FRAC_BITS];
        if (cmd.mul_hi)
        begin
            high_cut_reg <= prod[2*COUNT_W-1:FRAC_BITS];
            cum_reg      <= '0;
            idx_reg      <= '0;
        end
        if (cmd.scan_acc)
        begin
            cum_reg <= cum_next;
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.div_start)
        begin
            div_d_reg   <= div_d;
            div_rem_reg <= '0;
            div_q_reg   <= '0;
            div_cnt_reg <= 3'd7;
        end
        if (cmd.div_step)
        begin
            if (div_trial >= {1'b0, div_d_reg})
            begin
                div_rem_reg <= LEVEL_W'(div_trial - {1'b0, div_d_reg});
                div_q_reg   <= {div_q_reg[LEVEL_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_trial[LEVEL_W-1:0];
                div_q_reg   <= {div_q_reg[LEVEL_W-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (status.div_last)
            begin
                idx_reg   <= '0;
                acc_q_reg <= '0;
                acc_r_reg <= '0;
            end
        end
        if (cmd.fill)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (idx_reg > lower_reg)
            begin
                acc_q_reg <= fill_val;
                acc_r_reg <= r_new;
            end
        end
        if (cmd.load_out)
        begin
            out_pixel_reg  <= (report_reg || !map_built_reg) ? '0 : map_rd_reg;
            out_low_reg    <= lower_reg;
            out_high_reg   <= upper_reg;
            out_report_reg <= report_reg;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_pixel  = out_pixel_reg;
    assign rsp_low    = out_low_reg;
    assign rsp_high   = out_high_reg;
    assign rsp_report = out_report_reg;

endmodule

@@ hdl/histogram_contrast_stretch_top.sv @@
// ----------------------------------------------------------------------------
// histogram_contrast_stretch_top
// Two-pass percentile contrast stretch of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Operation: one transaction at a time. Accumulate is a read-modify-write
// of the histogram RAM, map lookup a registered RAM read plus output load.
// Finish runs the low and high cut multiplies, a read and an accumulate step
// per bin scanned up to the upper cut, the serial divider and a fill of all
// 256 map entries; the histogram RAM port and the serial map fill set its
// length. The result sits in an output register, so the next request is
// taken while it waits. No clearing pass is needed after reset.
module histogram_contrast_stretch_top
    import hcs_pkg::*;
#(
    parameter int MAX_PIXELS = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [FRAC_W-1:0]    cfg_data,
    hcs_req_if.sink              req,
    hcs_rsp_if.source            rsp
);

    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_PIXELS < 131071) ? COUNT_W'(MAX_PIXELS) : 17'd131071;

    hcs_cmd_t    cmd;
    hcs_status_t status;

    hcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .status      (status),
        .cmd         (cmd)
    );

    hcs_datapath #(
        .COUNT_CAP (COUNT_CAP)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_command (req.command),
        .req_pixel   (req.pixel_in),
        .cmd         (cmd),
        .status      (status),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .rsp_pixel   (rsp.pixel_out),
        .rsp_low     (rsp.low_index),
        .rsp_high    (rsp.high_index),
        .rsp_report  (rsp.is_report)
    );

`ifndef SYNTHESIS
    a_accum_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.command == CMD_ACCUM |=> !req.ready)
        else $error("accumulate did not hold off the next transaction");

    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.is_report |-> rsp.pixel_out == '0)
        else $error("report carries a nonzero pixel");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.low_index <= rsp.high_index)
        else $error("lower bound above upper bound");
`endif

endmodule
